// File: hdl/sco_pkg.sv
package sco_pkg;

  // default fraction bits of the position format
  localparam int FRAC_BITS_DEF = 16;
  // fraction bits of the unit axis
  localparam int UNIT_BITS = 28;
  // quotient bits of one unit axis component magnitude (0 .. 2^UNIT_BITS)
  localparam int QBITS = UNIT_BITS + 1;

  // region codes
  localparam logic [1:0] REG_CYL = 2'd0;
  localparam logic [1:0] REG_POS = 2'd1;
  localparam logic [1:0] REG_NEG = 2'd2;

  typedef struct packed {
    logic signed [31:0] sphere_x;
    logic signed [31:0] sphere_y;
    logic signed [31:0] sphere_z;
    logic signed [31:0] capsule_x;
    logic signed [31:0] capsule_y;
    logic signed [31:0] capsule_z;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic [30:0]        half_height;
    logic [30:0]        capsule_radius;
  } in_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] region;
    logic       axis_error;
  } out_t;

  // per item data that rides along the long pipeline sections
  typedef struct packed {
    logic [2:0][32:0] d;     // sphere minus capsule centre, signed
    logic [2:0][31:0] am;    // axis magnitudes, normalized after the shift stage
    logic [2:0]       neg;   // axis component signs
    logic [30:0]      h;     // half height
    logic [31:0]      rsum;  // radius sum
    logic             zero;  // zero axis
  } side_t;

  // magnitude of a signed 32 bit value
  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    mag32 = x[31] ? (~x + 32'd1) : x;
  endfunction

endpackage

// File: hdl/sphere_capsule_overlap_test.sv
// Sphere against capsule overlap test in signed fixed point. Each input beat
// carries the sphere and capsule centres, a capsule axis of any length, the
// half height and the capsule radius; the sphere radius comes from cfg_wdata
// (reset 1.0). The axis is normalized by a pipelined 32 stage square root and
// a 29 stage divider, the centre offset is projected on it, and the distance
// to the cylinder or the nearer cap centre is compared exactly in squares.
// One result beat per input beat, in order, through 5 front stages, 32
// square root stages, 29 divider stages and 9 back stages, the last being
// the output register. A new beat is taken every cycle; while
// out_stall holds a waiting result, the whole pipeline holds and in_stall is
// high. A zero axis gives axis_error with no hit.
module sphere_capsule_overlap_test import sco_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data
);

  localparam logic [30:0] RADIUS_ONE = 31'(64'd1 << FRAC_BITS);

  logic        en;
  logic [30:0] sphere_radius_r;

  // stage signals
  side_t a_side_r, a_side_nxt;
  logic  a_v_r;
  side_t b_side_r;
  logic [4:0] b_k_r, b_k_nxt;
  logic  b_v_r;
  side_t c_side_r, c_side_nxt;
  logic  c_v_r;
  side_t d_side_r;
  logic [2:0][63:0] d_sq_r, d_sq_nxt;
  logic  d_v_r;
  side_t e_side_r;
  logic [63:0] e_sq_r;
  logic  e_v_r;

  logic        sq_v;
  logic [31:0] sq_len;
  side_t       sq_side;
  logic                  dv_v;
  logic [2:0][QBITS-1:0] dv_q;
  side_t                 dv_side;

  side_t f_side_r;
  logic [2:0][QBITS-1:0] f_q_r;
  logic [2:0][62:0] f_pr_r, f_pr_nxt;
  logic  f_v_r;
  side_t g_side_r;
  logic [2:0][QBITS-1:0] g_q_r;
  logic signed [64:0] g_acc_r, g_acc_nxt;
  logic  g_v_r;
  side_t h_side_r;
  logic [2:0][QBITS-1:0] h_q_r;
  logic [33:0] h_pm_r, h_pm_nxt;
  logic        h_pneg_r;
  logic [1:0]  h_reg_r, h_reg_nxt;
  logic  h_v_r;
  side_t i_side_r;
  logic [2:0][62:0] i_prod_r, i_prod_nxt;
  logic [2:0]  i_sneg_r, i_sneg_nxt;
  logic [1:0]  i_reg_r;
  logic  i_v_r;
  side_t j_side_r;
  logic [2:0][36:0] j_v_r, j_v_nxt;
  logic [1:0]  j_reg_r;
  logic  j_vld_r;
  logic [2:0][31:0] k_m_r, k_m_nxt;
  logic        k_lt_r, k_lt_nxt;
  logic [31:0] k_rsum_r;
  logic        k_zero_r;
  logic [1:0]  k_reg_r;
  logic  k_v_r;
  logic [2:0][63:0] l_sq_r;
  logic [63:0] l_r2_r;
  logic        l_lt_r, l_zero_r;
  logic [1:0]  l_reg_r;
  logic  l_v_r;
  logic [65:0] m_sum_r;
  logic [63:0] m_r2_r;
  logic        m_lt_r, m_zero_r;
  logic [1:0]  m_reg_r;
  logic  m_v_r;
  out_t  out_data_r, out_data_nxt;
  logic  out_valid_r;

  // global advance: the pipeline moves unless a result waits on a stall
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // sphere radius register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sphere_radius_r <= RADIUS_ONE;
    end else if (cfg_we) begin
      sphere_radius_r <= cfg_wdata;
    end
  end

  // valid bits of the front and back stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0; b_v_r <= 1'b0; c_v_r <= 1'b0; d_v_r <= 1'b0; e_v_r <= 1'b0;
      f_v_r <= 1'b0; g_v_r <= 1'b0; h_v_r <= 1'b0; i_v_r <= 1'b0; j_vld_r <= 1'b0;
      k_v_r <= 1'b0; l_v_r <= 1'b0; m_v_r <= 1'b0; out_valid_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid; b_v_r <= a_v_r; c_v_r <= b_v_r; d_v_r <= c_v_r;
      e_v_r <= d_v_r;
      f_v_r <= dv_v; g_v_r <= f_v_r; h_v_r <= g_v_r; i_v_r <= h_v_r;
      j_vld_r <= i_v_r; k_v_r <= j_vld_r; l_v_r <= k_v_r; m_v_r <= l_v_r;
      out_valid_r <= m_v_r;
    end
  end

  // stage a: offsets, axis magnitudes, radius sum
  always_comb begin
    a_side_nxt.d[0] = 33'(in_data.sphere_x) - 33'(in_data.capsule_x);
    a_side_nxt.d[1] = 33'(in_data.sphere_y) - 33'(in_data.capsule_y);
    a_side_nxt.d[2] = 33'(in_data.sphere_z) - 33'(in_data.capsule_z);
    a_side_nxt.am[0] = mag32(in_data.axis_x);
    a_side_nxt.am[1] = mag32(in_data.axis_y);
    a_side_nxt.am[2] = mag32(in_data.axis_z);
    a_side_nxt.neg  = {in_data.axis_z[31], in_data.axis_y[31], in_data.axis_x[31]};
    a_side_nxt.h    = in_data.half_height;
    a_side_nxt.rsum = {1'b0, sphere_radius_r} + {1'b0, in_data.capsule_radius};
    a_side_nxt.zero = (in_data.axis_x == '0) && (in_data.axis_y == '0) &&
                      (in_data.axis_z == '0);
  end

  // stage b: shift count that brings the largest magnitude to 2^30 or more
  always_comb begin
    logic [31:0] orv;
    orv     = a_side_r.am[0] | a_side_r.am[1] | a_side_r.am[2];
    b_k_nxt = '0;
    if (!(orv[31] || orv[30])) begin
      for (int i = 0; i < 30; i++) begin
        if (orv[i]) b_k_nxt = 5'(30 - i);
      end
    end
  end

  // stage c: normalize the axis
  always_comb begin
    c_side_nxt = b_side_r;
    for (int i = 0; i < 3; i++) begin
      c_side_nxt.am[i] = b_side_r.am[i] << b_k_r;
    end
  end

  // stage d: squared components
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_sq_nxt[i] = 64'(c_side_r.am[i]) * 64'(c_side_r.am[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r <= a_side_nxt;
      b_side_r <= a_side_r;
      b_k_r    <= b_k_nxt;
      c_side_r <= c_side_nxt;
      d_side_r <= c_side_r;
      d_sq_r   <= d_sq_nxt;
      e_side_r <= d_side_r;
      e_sq_r   <= d_sq_r[0] + d_sq_r[1] + d_sq_r[2];
    end
  end

  // axis length
  sco_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (e_v_r),
    .in_sq     (e_sq_r),
    .in_side   (e_side_r),
    .out_valid (sq_v),
    .out_len   (sq_len),
    .out_side  (sq_side)
  );

  // unit axis magnitudes
  sco_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_v),
    .in_len    (sq_len),
    .in_side   (sq_side),
    .out_valid (dv_v),
    .out_q     (dv_q),
    .out_side  (dv_side)
  );

  // stage f: offset times unit axis, per component
  always_comb begin
    logic signed [32:0] ds;
    logic signed [29:0] us;
    logic signed [62:0] pr;
    for (int i = 0; i < 3; i++) begin
      ds = $signed(dv_side.d[i]);
      us = dv_side.neg[i] ? -$signed({1'b0, dv_q[i]}) : $signed({1'b0, dv_q[i]});
      pr = ds * us;
      f_pr_nxt[i] = pr;
    end
  end

  // stage g: projection sum
  assign g_acc_nxt = $signed(f_pr_r[0]) + $signed(f_pr_r[1]) + $signed(f_pr_r[2]);

  // stage h: projection magnitude and region
  always_comb begin
    logic [64:0] aabs;
    aabs     = g_acc_r[64] ? 65'(-g_acc_r) : 65'(g_acc_r);
    h_pm_nxt = aabs[61:28];
    if (h_pm_nxt < {3'b0, g_side_r.h}) begin
      h_reg_nxt = REG_CYL;
    end else if (!g_acc_r[64] && (h_pm_nxt != '0)) begin
      h_reg_nxt = REG_POS;
    end else begin
      h_reg_nxt = REG_NEG;
    end
  end

  // stage i: scaled axis point, sign of the subtracted term
  always_comb begin
    logic [33:0] mm;
    mm = (h_reg_r == REG_CYL) ? h_pm_r : {3'b0, h_side_r.h};
    for (int i = 0; i < 3; i++) begin
      i_prod_nxt[i] = 63'(mm) * 63'(h_q_r[i]);
      case (h_reg_r)
        REG_CYL: i_sneg_nxt[i] = h_pneg_r ^ h_side_r.neg[i];
        REG_POS: i_sneg_nxt[i] = h_side_r.neg[i];
        default: i_sneg_nxt[i] = !h_side_r.neg[i];
      endcase
    end
  end

  // stage j: offset to the nearest axis point
  always_comb begin
    logic signed [36:0] ds, ts;
    for (int i = 0; i < 3; i++) begin
      ds = 37'($signed(i_side_r.d[i]));
      ts = $signed({2'b0, i_prod_r[i][62:28]});
      j_v_nxt[i] = i_sneg_r[i] ? ds + ts : ds - ts;
    end
  end

  // stage k: component magnitudes against the radius sum
  always_comb begin
    logic [36:0] m;
    k_lt_nxt = 1'b1;
    for (int i = 0; i < 3; i++) begin
      m = j_v_r[i][36] ? 37'(-$signed(j_v_r[i])) : j_v_r[i];
      k_m_nxt[i] = m[31:0];
      if (m >= {5'b0, j_side_r.rsum}) k_lt_nxt = 1'b0;
    end
  end

  // stage n: result
  always_comb begin
    out_data_nxt.axis_error = m_zero_r;
    out_data_nxt.hit        = m_lt_r && !m_zero_r && (m_sum_r < {2'b0, m_r2_r});
    out_data_nxt.region     = m_zero_r ? REG_CYL : m_reg_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_side_r <= dv_side;
      f_q_r    <= dv_q;
      f_pr_r   <= f_pr_nxt;
      g_side_r <= f_side_r;
      g_q_r    <= f_q_r;
      g_acc_r  <= g_acc_nxt;
      h_side_r <= g_side_r;
      h_q_r    <= g_q_r;
      h_pm_r   <= h_pm_nxt;
      h_pneg_r <= g_acc_r[64];
      h_reg_r  <= h_reg_nxt;
      i_side_r <= h_side_r;
      i_prod_r <= i_prod_nxt;
      i_sneg_r <= i_sneg_nxt;
      i_reg_r  <= h_reg_r;
      j_side_r <= i_side_r;
      j_v_r    <= j_v_nxt;
      j_reg_r  <= i_reg_r;
      k_m_r    <= k_m_nxt;
      k_lt_r   <= k_lt_nxt;
      k_rsum_r <= j_side_r.rsum;
      k_zero_r <= j_side_r.zero;
      k_reg_r  <= j_reg_r;
      for (int i = 0; i < 3; i++) begin
        l_sq_r[i] <= 64'(k_m_r[i]) * 64'(k_m_r[i]);
      end
      l_r2_r   <= 64'(k_rsum_r) * 64'(k_rsum_r);
      l_lt_r   <= k_lt_r;
      l_zero_r <= k_zero_r;
      l_reg_r  <= k_reg_r;
      m_sum_r  <= 66'(l_sq_r[0]) + 66'(l_sq_r[1]) + 66'(l_sq_r[2]);
      m_r2_r   <= l_r2_r;
      m_lt_r   <= l_lt_r;
      m_zero_r <= l_zero_r;
      m_reg_r  <= l_reg_r;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // a normalized nonzero axis has length of at least 2^30
  a_len_norm: assert property (@(posedge clk) disable iff (!rst_n)
    sq_v && !sq_side.zero |-> sq_len[31:30] != 2'b00)
    else $error("axis length below normalized range");

  // unit axis components never exceed one
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    dv_v && !dv_side.zero |->
      dv_q[0] <= QBITS'(1 << UNIT_BITS) && dv_q[1] <= QBITS'(1 << UNIT_BITS) &&
      dv_q[2] <= QBITS'(1 << UNIT_BITS))
    else $error("unit axis component above one");

  // a zero axis never reports a hit
  a_zero_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.axis_error |-> !out_data.hit && out_data.region == REG_CYL)
    else $error("hit on zero axis");

  // a result only leaves the pipeline end when the stage before it held one
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(m_v_r))
    else $error("result without source beat");
`endif

endmodule

// File: hdl/sco_sqrt.sv
module sco_sqrt import sco_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] in_sq,
  input  side_t       in_side,
  output logic        out_valid,
  output logic [31:0] out_len,
  output side_t       out_side
);

  localparam int STEPS = 32;

  logic [63:0] s_r   [STEPS];
  logic [63:0] res_r [STEPS];
  side_t       side_r[STEPS];
  logic        v_r   [STEPS];

  // one result bit per stage
  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] s_in, res_in, t;
    side_t       side_in;
    logic        v_in;

    if (j == 0) begin : g_first
      assign s_in    = in_sq;
      assign res_in  = 64'd0;
      assign side_in = in_side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign s_in    = s_r[j-1];
      assign res_in  = res_r[j-1];
      assign side_in = side_r[j-1];
      assign v_in    = v_r[j-1];
    end

    assign t = res_in + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[j] <= side_in;
        if (s_in >= t) begin
          s_r[j]   <= s_in - t;
          res_r[j] <= (res_in >> 1) + BIT;
        end else begin
          s_r[j]   <= s_in;
          res_r[j] <= res_in >> 1;
        end
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_len   = res_r[STEPS-1][31:0];
  assign out_side  = side_r[STEPS-1];

endmodule

// File: hdl/sco_div.sv
module sco_div import sco_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [31:0]           in_len,
  input  side_t                 in_side,
  output logic                  out_valid,
  output logic [2:0][QBITS-1:0] out_q,
  output side_t                 out_side
);

  // three lanes of restoring division, one quotient bit per stage
  logic [2:0][31:0]      r_r   [QBITS];
  logic [2:0][QBITS-1:0] q_r   [QBITS];
  logic [31:0]           len_r [QBITS];
  side_t                 side_r[QBITS];
  logic                  v_r   [QBITS];

  for (genvar j = 0; j < QBITS; j++) begin : g_step
    logic [2:0][31:0]      r_in;
    logic [2:0][QBITS-1:0] q_in;
    logic [31:0]           len_in;
    side_t                 side_in;
    logic                  v_in;
    logic [2:0][32:0]      cand;
    logic [2:0]            ge;

    if (j == 0) begin : g_first
      assign r_in    = in_side.am;
      assign q_in    = '0;
      assign len_in  = in_len;
      assign side_in = in_side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign r_in    = r_r[j-1];
      assign q_in    = q_r[j-1];
      assign len_in  = len_r[j-1];
      assign side_in = side_r[j-1];
      assign v_in    = v_r[j-1];
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
      if (j == 0) begin : g_noshift
        assign cand[i] = {1'b0, r_in[i]};
      end else begin : g_shift
        assign cand[i] = {r_in[i], 1'b0};
      end
      assign ge[i] = cand[i] >= {1'b0, len_in};

      always_ff @(posedge clk) begin
        if (en) begin
          r_r[j][i] <= ge[i] ? 32'(cand[i] - {1'b0, len_in}) : cand[i][31:0];
          q_r[j][i] <= {q_in[i][QBITS-2:0], ge[i]};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len_r[j]  <= len_in;
        side_r[j] <= side_in;
      end
    end
  end

  assign out_valid = v_r[QBITS-1];
  assign out_q     = q_r[QBITS-1];
  assign out_side  = side_r[QBITS-1];

endmodule

// File: dv/sphere_capsule_overlap_test_tb.sv
`timescale 1ns / 100ps

module sphere_capsule_overlap_test_tb;
  import sco_pkg::*;

  localparam int LATENCY   = 75;
  localparam int IDLE_MAX  = 5000;
  localparam logic [30:0] ONE_Q16 = 31'd65536;
  localparam logic [30:0] RAD_MAX = 31'h7fff_ffff;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [30:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;

  // model copy of the sphere radius register
  logic [30:0] sphere_radius_q = ONE_Q16;
  out_t        pending_results[$];
  int          failures = 0;
  int          idle_cycles = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          hits_seen = 0;
  int          region_seen[3] = '{0, 0, 0};
  int          axis_err_seen = 0;
  int          radius_writes = 0;

  sphere_capsule_overlap_test dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // magnitude of a signed 64 bit value
  function automatic longint unsigned abs64(longint x);
    abs64 = (x < 0) ? longint'(-x) : x;
  endfunction

  // (a * u) scaled down by the unit fraction bits, truncated toward zero
  function automatic longint scale_by_unit(longint a, longint u);
    longint unsigned q;
    q = (abs64(a) * abs64(u)) >> UNIT_BITS;
    scale_by_unit = ((a < 0) != (u < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // expected result of one overlap test
  function automatic out_t predict_overlap(in_t x, logic [30:0] rad);
    longint d[3], a[3], u[3], v[3];
    longint acc, p;
    longint unsigned am[3], maxm, sq, len, h, rsum, pm, rem, root, bitv, r2, sumsq, m, m2;
    int i, k;
    out_t o;
    d[0] = longint'($signed(x.sphere_x)) - longint'($signed(x.capsule_x));
    d[1] = longint'($signed(x.sphere_y)) - longint'($signed(x.capsule_y));
    d[2] = longint'($signed(x.sphere_z)) - longint'($signed(x.capsule_z));
    a[0] = longint'($signed(x.axis_x));
    a[1] = longint'($signed(x.axis_y));
    a[2] = longint'($signed(x.axis_z));
    maxm = 0;
    for (i = 0; i < 3; i++) begin
      am[i] = abs64(a[i]);
      if (am[i] > maxm) maxm = am[i];
    end
    h = x.half_height;
    rsum = longint'(rad) + longint'(x.capsule_radius);
    o = '0;
    if (maxm == 0) begin
      o.axis_error = 1'b1;
      o.region = REG_CYL;
      return o;
    end
    // bring the largest axis component up to at least 2^30
    for (k = 0; k < 31 && maxm < (64'd1 << 30); k++) begin
      maxm = maxm << 1;
      for (i = 0; i < 3; i++) am[i] = am[i] << 1;
    end
    sq = 0;
    for (i = 0; i < 3; i++) sq += am[i] * am[i];
    // bitwise integer square root
    rem = sq;
    root = 0;
    bitv = 64'd1 << 62;
    for (k = 0; k < 32; k++) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    len = root;
    for (i = 0; i < 3; i++) begin
      m = (am[i] << UNIT_BITS) / len;
      u[i] = (a[i] < 0) ? -longint'(m) : longint'(m);
    end
    // projection of the offset on the unit axis
    acc = 0;
    for (i = 0; i < 3; i++) acc += d[i] * u[i];
    pm = abs64(acc) >> UNIT_BITS;
    p = (acc < 0) ? -longint'(pm) : longint'(pm);
    if (pm < h) begin
      o.region = REG_CYL;
      for (i = 0; i < 3; i++) v[i] = d[i] - scale_by_unit(p, u[i]);
    end else if (p > 0) begin
      o.region = REG_POS;
      for (i = 0; i < 3; i++) v[i] = d[i] - scale_by_unit(longint'(h), u[i]);
    end else begin
      o.region = REG_NEG;
      for (i = 0; i < 3; i++) v[i] = d[i] + scale_by_unit(longint'(h), u[i]);
    end
    // exact squared compare, stopping early instead of overflowing
    o.hit = 1'b1;
    r2 = rsum * rsum;
    sumsq = 0;
    for (i = 0; i < 3; i++) begin
      m = abs64(v[i]);
      if (o.hit) begin
        if (m >= rsum) begin
          o.hit = 1'b0;
        end else begin
          m2 = m * m;
          if (m2 >= r2 - sumsq) o.hit = 1'b0;
          else sumsq += m2;
        end
      end
    end
    return o;
  endfunction

  // random gap length: mostly none, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one beat and record its expected result on acceptance
  task automatic send_item(in_t x);
    int g;
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(predict_overlap(x, sphere_radius_q));
    beats_in++;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // hold the sender until every result is back, then let the pipe empty
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_radius(logic [30:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sphere_radius_q = value;
    radius_writes++;
  endtask

  function automatic in_t make_item(logic signed [31:0] sx, logic signed [31:0] sy,
                                    logic signed [31:0] sz, logic signed [31:0] cx,
                                    logic signed [31:0] cy, logic signed [31:0] cz,
                                    logic signed [31:0] ax, logic signed [31:0] ay,
                                    logic signed [31:0] az, logic [30:0] hh,
                                    logic [30:0] cr);
    in_t x;
    x.sphere_x = sx; x.sphere_y = sy; x.sphere_z = sz;
    x.capsule_x = cx; x.capsule_y = cy; x.capsule_z = cz;
    x.axis_x = ax; x.axis_y = ay; x.axis_z = az;
    x.half_height = hh;
    x.capsule_radius = cr;
    return x;
  endfunction

  // random signed value shifted down to a scale
  function automatic logic signed [31:0] rnd_scaled(int s);
    logic signed [31:0] r;
    r = $urandom;
    return r >>> s;
  endfunction

  // mostly a sphere placed near a capsule, sometimes raw noise
  function automatic in_t random_item();
    in_t x;
    int sc, sa;
    logic [31:0] b;
    logic [351:0] raw;
    x = '0;
    if ($urandom_range(0, 9) == 0) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom};
      x = raw[$bits(in_t)-1:0];
      return x;
    end
    sc = $urandom_range(2, 24);
    sa = $urandom_range(0, 30);
    x.capsule_x = rnd_scaled(2);
    x.capsule_y = rnd_scaled(2);
    x.capsule_z = rnd_scaled(2);
    x.sphere_x = x.capsule_x + rnd_scaled(sc);
    x.sphere_y = x.capsule_y + rnd_scaled(sc);
    x.sphere_z = x.capsule_z + rnd_scaled(sc);
    x.axis_x = rnd_scaled(sa);
    x.axis_y = rnd_scaled($urandom_range(0, 30));
    x.axis_z = rnd_scaled($urandom_range(0, 30));
    // axis along one coordinate, or rarely no axis at all
    case ($urandom_range(0, 19))
      0: begin x.axis_x = '0; x.axis_y = '0; x.axis_z = '0; end
      1, 2: begin x.axis_y = '0; x.axis_z = '0; end
      default: ;
    endcase
    b = $urandom;
    x.half_height = b[30:0] >> (sc + $urandom_range(0, 2));
    b = $urandom;
    x.capsule_radius = b[30:0] >> (sc + $urandom_range(0, 2));
    return x;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %p", out_data);
        failures++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.hit !== exp_r.hit) begin
          $error("hit: expected %0b actual %0b", exp_r.hit, out_data.hit);
          failures++;
        end
        if (out_data.region !== exp_r.region) begin
          $error("region: expected %0d actual %0d", exp_r.region, out_data.region);
          failures++;
        end
        if (out_data.axis_error !== exp_r.axis_error) begin
          $error("axis_error: expected %0b actual %0b", exp_r.axis_error,
                 out_data.axis_error);
          failures++;
        end
        if (exp_r.hit) hits_seen++;
        if (exp_r.axis_error) axis_err_seen++;
        else if (exp_r.region <= REG_NEG) region_seen[exp_r.region]++;
      end
    end
  end

  // receiver stall: quiet stretches and busy stretches
  always @(posedge clk) begin
    int busy;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      busy = ($urandom_range(0, 999) < 8) ? $urandom_range(10, 40) : 0;
      if (busy > 0) begin
        out_stall <= 1'b1;
        repeat (busy) @(posedge clk);
        out_stall <= 1'b0;
      end else if ((beats_out / 200) % 2 == 0) begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any accepted beat while work is waiting
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n ||
        (pending_results.size() == 0 && !in_valid))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // extremes and named special cases at the default radius
  task automatic test_directed();
    logic signed [31:0] mn, mx;
    mn = 32'sh8000_0000;
    mx = 32'sh7fff_ffff;
    // zero axis
    send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, ONE_Q16, ONE_Q16));
    // same centre, zero half height: projection zero lands on the negative cap
    send_item(make_item(0, 0, 0, 0, 0, 0, 32'sd65536, 0, 0, 0, ONE_Q16));
    // cylinder part, inside and just touching
    send_item(make_item(0, 32'sd65536, 0, 0, 0, 0, 32'sd65536, 0, 0, 31'd131072, ONE_Q16));
    send_item(make_item(0, 32'sd196608, 0, 0, 0, 0, 32'sd1, 0, 0, 31'd131072, 31'd131072));
    // positive cap, an axis across the offset (cylinder), a reversed axis (positive cap)
    send_item(make_item(32'sd250000, 0, 0, 0, 0, 0, 32'sd7, 0, 0, 31'd131072, ONE_Q16));
    send_item(make_item(-32'sd250000, 0, 0, 0, 0, 0, 0, 32'sd3, 32'sd3, 31'd131072, ONE_Q16));
    send_item(make_item(-32'sd250000, 0, 0, 0, 0, 0, -32'sd9, 0, 0, 31'd131072, ONE_Q16));
    // extremes of every field
    send_item(make_item(mx, mx, mx, mn, mn, mn, mn, mn, mn, RAD_MAX, RAD_MAX));
    send_item(make_item(mn, mn, mn, mx, mx, mx, mx, mx, mx, 0, 0));
    send_item(make_item(mn, mx, mn, mn, mx, mn, mn, mx, 32'sd1, RAD_MAX, 0));
    send_item(make_item(mx, mn, 0, mx, mn, 0, 32'sd1, 32'sd1, 32'sd1, 0, RAD_MAX));
    send_item(make_item(32'sd1, -32'sd1, 0, 0, 0, 0, mn, 0, 0, 0, 0));
    send_item(make_item(0, 0, 0, 0, 0, 0, 32'sd1, mn, mx, 31'd1, 31'd1));
    send_item(make_item(-32'sd1, -32'sd1, -32'sd1, 0, 0, 0, -32'sd1, -32'sd1, -32'sd1,
                        31'd1, 31'd1));
  endtask

  // radius register extremes: zero radius sum, largest radius, default
  task automatic test_radius_sweep();
    write_radius(31'd0);
    send_item(make_item(0, 0, 0, 0, 0, 0, 32'sd65536, 0, 0, ONE_Q16, 0));
    send_item(make_item(32'sd5, 0, 0, 0, 0, 0, 0, 32'sd65536, 0, 0, 0));
    send_item(make_item(0, 0, 0, 0, 0, 0, 32'sd65536, 0, 0, ONE_Q16, 31'd1));
    repeat (20) send_item(random_item());
    write_radius(RAD_MAX);
    send_item(make_item(32'sh7fff_ffff, 0, 0, 32'sh8000_0000, 0, 0, 0, 0, 32'sd1,
                        0, RAD_MAX));
    repeat (20) send_item(random_item());
    write_radius(ONE_Q16);
  endtask

  // random stream, radius changing between phases
  task automatic test_random_stream();
    logic [31:0] b;
    for (int phase = 0; phase < 5; phase++) begin
      b = $urandom;
      write_radius(b[30:0] >> $urandom_range(6, 20));
      repeat (340) send_item(random_item());
    end
    write_radius(ONE_Q16);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_radius_sweep();
    test_random_stream();
    drain();
    $display("%0d beats in, %0d out over %0d radius settings", beats_in, beats_out,
             radius_writes);
    $display("hits %0d, cylinder %0d, positive cap %0d, negative cap %0d, zero axis %0d",
             hits_seen, region_seen[0], region_seen[1], region_seen[2], axis_err_seen);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/sco_pkg.sv
hdl/sco_sqrt.sv
hdl/sco_div.sv
hdl/sphere_capsule_overlap_test.sv
dv/sphere_capsule_overlap_test_tb.sv
